>>> hw/rtl/assert_macros.svh
// Assertion macros used by the roulette wheel selector top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define RWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define RWS_ASSERT_NEVER(label, cond, msg) \
  `RWS_ASSERT(label, !(cond), msg)

`endif

>>> hw/rtl/rws_pkg.sv
// Types, codes and default sizes for the roulette wheel selector.
package rws_pkg;

  localparam int unsigned POP_SLOTS_DEF    = 256;
  localparam int unsigned FITNESS_BITS_DEF = 16;
  localparam int unsigned RANDOM_BITS_DEF  = 16;

  localparam int unsigned POP_COUNT_W   = 9;
  localparam logic [POP_COUNT_W-1:0] POP_COUNT_RST = 9'd256;

  typedef enum logic [0:0] {
    ACT_LOAD   = 1'b0,
    ACT_SELECT = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STAT_LOAD = 2'd0,
    STAT_PICK = 2'd1,
    STAT_ZERO = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  slot;
    logic [15:0] fitness;
    logic [15:0] random_fraction;
  } item_t;

  typedef struct packed {
    logic [7:0] picked_slot;
    status_e    status;
  } result_t;

  typedef struct packed {
    logic clear;
    logic sum_en;
    logic walk_en;
  } acc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic total_zero;
    logic hit;
  } acc_stat_t;

endpackage

>>> hw/rtl/rws_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rws_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rws_accum.sv
// Running sums, weighted random threshold and walk compare of the selector.
module rws_accum #(
  parameter int unsigned FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF,
  parameter int unsigned RANDOM_BITS  = rws_pkg::RANDOM_BITS_DEF,
  parameter int unsigned TOT_W        = rws_pkg::FITNESS_BITS_DEF + 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rws_pkg::acc_ctrl_t      ctrl_i,
  input  logic [RANDOM_BITS-1:0]  rnd_i,
  input  logic [FITNESS_BITS-1:0] rdata_i,
  input  logic                    rdata_vld_i,
  output rws_pkg::acc_stat_t      stat_o
);

  localparam int unsigned PW = RANDOM_BITS + FITNESS_BITS;
  localparam int unsigned RW = RANDOM_BITS + TOT_W;

  logic [FITNESS_BITS-1:0] fit_q;
  logic [PW-1:0]           prod_d, prod_q;
  logic                    pvld_q;
  logic [TOT_W-1:0]        total_q;
  logic [RW-1:0]           rt_q;
  logic [TOT_W-1:0]        cum_d, cum_q;

  // r * fitness per slot, summed, gives r * total without a wide multiply
  assign prod_d = {{FITNESS_BITS{1'b0}}, rnd_i} * {{RANDOM_BITS{1'b0}}, rdata_i};
  assign cum_d  = cum_q + TOT_W'(rdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= ctrl_i.sum_en && rdata_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    fit_q  <= rdata_i;
    prod_q <= prod_d;
    if (ctrl_i.clear) begin
      total_q <= '0;
      rt_q    <= '0;
      cum_q   <= '0;
    end else begin
      if (pvld_q) begin
        total_q <= total_q + TOT_W'(fit_q);
        rt_q    <= rt_q + RW'(prod_q);
      end
      if (ctrl_i.walk_en && rdata_vld_i) begin
        cum_q <= cum_d;
      end
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.busy       = pvld_q;
    stat_o.total_zero = (total_q == '0);
    stat_o.hit        = ctrl_i.walk_en && rdata_vld_i &&
                        ({cum_d, {RANDOM_BITS{1'b0}}} > rt_q);
  end

endmodule

>>> hw/rtl/roulette_wheel_selector_unit.sv
// Top level of the fitness-proportionate roulette wheel selector.
// A summing pass and then a walk that stops at the chosen slot share one read port.
// A selection on a zero fitness total ends after the summing pass, without a walk.
// One transaction at a time: loads 1 per cycle while the output does not stall.
// After reset a clearing pass writes zero to every slot, with the input stalled.
module roulette_wheel_selector_unit #(
  parameter int unsigned POP_SLOTS    = rws_pkg::POP_SLOTS_DEF,
  parameter int unsigned FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF,
  parameter int unsigned RANDOM_BITS  = rws_pkg::RANDOM_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rws_pkg::POP_COUNT_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rws_pkg::item_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rws_pkg::result_t                out_data_o
);

`include "assert_macros.svh"

  localparam int unsigned AW    = $clog2(POP_SLOTS);
  localparam int unsigned CW    = $clog2(POP_SLOTS + 1);
  localparam int unsigned TOT_W = FITNESS_BITS + AW;

  rws_pkg::state_e state_q, state_d;
  logic [rws_pkg::POP_COUNT_W-1:0] pop_count_q;
  logic [CW-1:0]  idx_q, idx_d;
  logic [AW-1:0]  rd_idx_q;
  logic           rd_vld_q, rd_vld_d;
  logic [RANDOM_BITS-1:0] rnd_q;
  rws_pkg::result_t res_q, res_d;
  logic             out_valid_q, out_valid_d;
  rws_pkg::result_t out_data_q, out_data_d;

  logic [CW-1:0]  active;
  logic           in_acc, out_free, issue, fin;
  rws_pkg::result_t fin_res;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [FITNESS_BITS-1:0] ram_wdata, ram_rdata;
  rws_pkg::acc_ctrl_t acc_ctrl;
  rws_pkg::acc_stat_t acc_stat;

  always_comb begin
    if (32'(pop_count_q) > POP_SLOTS) begin
      active = CW'(POP_SLOTS);
    end else begin
      active = CW'(pop_count_q);
    end
  end

  assign in_stall_o = (state_q != rws_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  rws_ram #(
    .WIDTH(FITNESS_BITS),
    .DEPTH(POP_SLOTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  rws_accum #(
    .FITNESS_BITS(FITNESS_BITS),
    .RANDOM_BITS (RANDOM_BITS),
    .TOT_W       (TOT_W)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (acc_ctrl),
    .rnd_i      (rnd_q),
    .rdata_i    (ram_rdata),
    .rdata_vld_i(rd_vld_q),
    .stat_o     (acc_stat)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    res_d       = res_q;
    issue       = 1'b0;
    fin         = 1'b0;
    fin_res     = '0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[AW-1:0];
    ram_wdata   = '0;
    acc_ctrl    = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    case (state_q)
      rws_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (idx_q == CW'(POP_SLOTS - 1)) begin
          idx_d   = '0;
          state_d = rws_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      rws_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.action == rws_pkg::ACT_LOAD) begin
            // Slots beyond the store are dropped but still answered
            ram_we         = (32'(in_data_i.slot) < POP_SLOTS);
            ram_waddr      = AW'(in_data_i.slot);
            ram_wdata      = FITNESS_BITS'(in_data_i.fitness);
            fin            = 1'b1;
            fin_res.status = rws_pkg::STAT_LOAD;
          end else begin
            acc_ctrl.clear = 1'b1;
            idx_d          = '0;
            state_d        = rws_pkg::ST_SUM;
          end
        end
      end
      rws_pkg::ST_SUM: begin
        acc_ctrl.sum_en = 1'b1;
        if (idx_q < active) begin
          issue = 1'b1;
          idx_d = idx_q + CW'(1);
        end else if (!rd_vld_q && !acc_stat.busy) begin
          if (acc_stat.total_zero) begin
            fin            = 1'b1;
            fin_res.status = rws_pkg::STAT_ZERO;
          end else begin
            idx_d   = '0;
            state_d = rws_pkg::ST_WALK;
          end
        end
      end
      rws_pkg::ST_WALK: begin
        acc_ctrl.walk_en = 1'b1;
        // The last active slot always qualifies
        if (rd_vld_q && (acc_stat.hit || CW'(rd_idx_q) == active - CW'(1))) begin
          fin                 = 1'b1;
          fin_res.status      = rws_pkg::STAT_PICK;
          fin_res.picked_slot = 8'(rd_idx_q);
        end else if (idx_q < active) begin
          issue = 1'b1;
          idx_d = idx_q + CW'(1);
        end
      end
      rws_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = rws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rws_pkg::ST_IDLE;
      end
    endcase

    // Hand the result to the output register, or hold it until it drains
    if (fin) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_data_d  = fin_res;
        state_d     = rws_pkg::ST_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = rws_pkg::ST_DONE;
      end
    end
  end

  assign rd_vld_d = issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rws_pkg::ST_CLEAR;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pop_count_q <= rws_pkg::POP_COUNT_RST;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        pop_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    out_data_q <= out_data_d;
    if (issue) begin
      rd_idx_q <= idx_q[AW-1:0];
    end
    if (in_acc) begin
      rnd_q <= RANDOM_BITS'(in_data_i.random_fraction);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `RWS_ASSERT(a_select_starts_sum,
              in_acc && in_data_i.action == rws_pkg::ACT_SELECT |=> state_q == rws_pkg::ST_SUM,
              "selection did not start the summing pass")
  `RWS_ASSERT(a_done_holds_output,
              state_q == rws_pkg::ST_DONE |-> out_valid_q,
              "held result while output register empty")
  `RWS_ASSERT_NEVER(a_write_while_busy,
                    ram_we && state_q != rws_pkg::ST_IDLE && state_q != rws_pkg::ST_CLEAR,
                    "store written during a selection")
  `RWS_ASSERT(a_walk_in_range,
              state_q == rws_pkg::ST_WALK && rd_vld_q |-> CW'(rd_idx_q) < active,
              "walk read beyond the active slots")
  `RWS_ASSERT(a_walk_nonzero_total,
              state_q == rws_pkg::ST_WALK |-> !acc_stat.total_zero,
              "walk entered with zero total")

endmodule
